### rtl/dq_pkg.sv
// Package for the double-ended queue: sizes, command and status codes,
// beat payload structs and ring index helpers.
// Self-contained; used by double_ended_queue_top.
`timescale 1ns / 1ps

package dq_pkg;

    // Storage sizes.
    localparam int DEPTH     = 16;
    localparam int WORD_BITS = 32;
    localparam int IDX_BITS  = $clog2(DEPTH);
    localparam int CNT_BITS  = $clog2(DEPTH + 1);
    localparam int SUM_BITS  = CNT_BITS + 1;

    // Fixed field widths of the beats.
    localparam int CMD_BITS  = 3;
    localparam int DATA_BITS = 32;
    localparam int OCC_BITS  = 5;

    // Command codes; unused codes behave as a peek.
    localparam logic [CMD_BITS-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_PEEK       = 3'd4;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } state_t;

    typedef logic [IDX_BITS-1:0]  idx_t;
    typedef logic [CNT_BITS-1:0]  cnt_t;
    typedef logic [WORD_BITS-1:0] word_t;

    typedef struct packed {
        logic [CMD_BITS-1:0]         command;
        logic signed [DATA_BITS-1:0] value;
    } cmd_item_t;

    typedef struct packed {
        status_t                     status;
        logic signed [DATA_BITS-1:0] front_word;
        logic signed [DATA_BITS-1:0] back_word;
        logic [OCC_BITS-1:0]         occupancy;
        logic                        empty_flag;
    } rsp_item_t;

    // Ring position of base plus offset, where offset is at most DEPTH.
    function automatic idx_t ring_add(input idx_t base, input cnt_t offset);
        logic [SUM_BITS-1:0] sum;
        sum = SUM_BITS'(base) + SUM_BITS'(offset);
        if (sum >= SUM_BITS'(DEPTH))
        begin
            sum = sum - SUM_BITS'(DEPTH);
        end
        return IDX_BITS'(sum);
    endfunction

    // Ring position one step towards the front.
    function automatic idx_t ring_dec(input idx_t base);
        return (base == '0) ? IDX_BITS'(DEPTH - 1) : base - IDX_BITS'(1);
    endfunction

    // Ring position one step towards the back.
    function automatic idx_t ring_inc(input idx_t base);
        return (base == IDX_BITS'(DEPTH - 1)) ? '0 : base + IDX_BITS'(1);
    endfunction

    // Builds a response beat from the state after the step.
    function automatic rsp_item_t make_rsp(input status_t st, input word_t front,
                                           input word_t back, input cnt_t count);
        rsp_item_t r;
        r.status     = st;
        r.front_word = (count == '0) ? '0 : DATA_BITS'(front);
        r.back_word  = (count == '0) ? '0 : DATA_BITS'(back);
        r.occupancy  = OCC_BITS'(count);
        r.empty_flag = (count == '0);
        return r;
    endfunction

endpackage

### rtl/dq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/double_ended_queue_top.sv
// Top level of the bounded double-ended queue: ring control, front and back
// word registers and the response register. Depends on dq_pkg and dq_ram.
//
//  channel | valid     | ready     | payload   | beat
//  --------+-----------+-----------+-----------+----------------------------
//  command | cmd_valid | cmd_ready | cmd_data  | one command (push/pop/peek)
//  result  | rsp_valid | rsp_ready | rsp_data  | one result per command
//
// Pushes, peeks, refused commands and pops that leave fewer than two words
// answer from the idle state; a pop that leaves two or more words also passes
// through the read state to fetch the new end word from the registered RAM.
// Reset clears the head index, the count and the handshake state; the RAM
// is not cleared, as only occupied entries are ever read.
// A command is taken while the last result is still waiting only if that
// result is taken in the same cycle; a stalled result holds the block.
`timescale 1ns / 1ps

module double_ended_queue_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  dq_pkg::cmd_item_t cmd_data,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output dq_pkg::rsp_item_t rsp_data
);

    dq_pkg::state_t    state_reg, state_next;
    dq_pkg::idx_t      head_reg, head_next;
    dq_pkg::cnt_t      count_reg, count_next;
    dq_pkg::word_t     front_reg, front_next;
    dq_pkg::word_t     back_reg, back_next;
    logic              pend_front_reg, pend_front_next;
    logic              out_valid_reg, out_valid_next;
    dq_pkg::rsp_item_t out_data_reg, out_data_next;

    logic              wr_en;
    dq_pkg::idx_t      wr_addr;
    dq_pkg::word_t     wr_word;
    logic              rd_en;
    dq_pkg::idx_t      rd_addr;
    dq_pkg::word_t     rd_word;

    dq_pkg::status_t   status_v;
    logic              load_rsp;
    logic              is_full;
    logic              is_void;

    // Word store.
    dq_ram #(
        .WIDTH (dq_pkg::WORD_BITS),
        .DEPTH (dq_pkg::DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_word),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    assign is_full = (count_reg == dq_pkg::CNT_BITS'(dq_pkg::DEPTH));
    assign is_void = (count_reg == '0);
    assign wr_word = dq_pkg::WORD_BITS'($unsigned(cmd_data.value));

    // Control state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dq_pkg::S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        front_reg      <= front_next;
        back_reg       <= back_next;
        pend_front_reg <= pend_front_next;
        out_data_reg   <= out_data_next;
    end

    // Command decode, ring update and response build.
    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        front_next      = front_reg;
        back_next       = back_reg;
        pend_front_next = pend_front_reg;
        out_valid_next  = out_valid_reg && !rsp_ready;
        out_data_next   = out_data_reg;
        wr_en           = 1'b0;
        wr_addr         = head_reg;
        rd_en           = 1'b0;
        rd_addr         = head_reg;
        status_v        = dq_pkg::ST_OK;
        load_rsp        = 1'b0;
        cmd_ready       = (state_reg == dq_pkg::S_IDLE) && (!out_valid_reg || rsp_ready);

        case (state_reg)
            dq_pkg::S_IDLE:
            begin
                if (cmd_valid && cmd_ready)
                begin
                    case (cmd_data.command)
                        dq_pkg::CMD_PUSH_FRONT, dq_pkg::CMD_PUSH_BACK:
                        begin
                            load_rsp = 1'b1;
                            if (is_full)
                            begin
                                status_v = dq_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + dq_pkg::CNT_BITS'(1);
                                if (cmd_data.command == dq_pkg::CMD_PUSH_FRONT)
                                begin
                                    head_next  = dq_pkg::ring_dec(head_reg);
                                    wr_addr    = head_next;
                                    front_next = wr_word;
                                    if (is_void)
                                    begin
                                        back_next = wr_word;
                                    end
                                end
                                else
                                begin
                                    wr_addr   = dq_pkg::ring_add(head_reg, count_reg);
                                    back_next = wr_word;
                                    if (is_void)
                                    begin
                                        front_next = wr_word;
                                    end
                                end
                            end
                        end
                        dq_pkg::CMD_POP_FRONT, dq_pkg::CMD_POP_BACK:
                        begin
                            if (is_void)
                            begin
                                status_v = dq_pkg::ST_EMPTY;
                                load_rsp = 1'b1;
                            end
                            else
                            begin
                                count_next = count_reg - dq_pkg::CNT_BITS'(1);
                                if (cmd_data.command == dq_pkg::CMD_POP_FRONT)
                                begin
                                    head_next = dq_pkg::ring_inc(head_reg);
                                end
                                if (count_reg == dq_pkg::CNT_BITS'(1))
                                begin
                                    load_rsp = 1'b1;
                                end
                                else if (count_reg == dq_pkg::CNT_BITS'(2))
                                begin
                                    // One word remains: both ends are that word.
                                    load_rsp = 1'b1;
                                    if (cmd_data.command == dq_pkg::CMD_POP_FRONT)
                                    begin
                                        front_next = back_reg;
                                    end
                                    else
                                    begin
                                        back_next = front_reg;
                                    end
                                end
                                else
                                begin
                                    // Fetch the new end word from the store.
                                    rd_en           = 1'b1;
                                    pend_front_next =
                                        (cmd_data.command == dq_pkg::CMD_POP_FRONT);
                                    if (cmd_data.command == dq_pkg::CMD_POP_FRONT)
                                    begin
                                        rd_addr = head_next;
                                    end
                                    else
                                    begin
                                        rd_addr = dq_pkg::ring_add(head_reg,
                                            count_reg - dq_pkg::CNT_BITS'(2));
                                    end
                                    state_next = dq_pkg::S_READ;
                                end
                            end
                        end
                        default:
                        begin
                            // Peek and unused codes.
                            load_rsp = 1'b1;
                            if (is_void)
                            begin
                                status_v = dq_pkg::ST_EMPTY;
                            end
                        end
                    endcase
                end
            end
            dq_pkg::S_READ:
            begin
                if (pend_front_reg)
                begin
                    front_next = rd_word;
                end
                else
                begin
                    back_next = rd_word;
                end
                load_rsp   = 1'b1;
                state_next = dq_pkg::S_IDLE;
            end
            default:
            begin
                state_next = dq_pkg::S_IDLE;
            end
        endcase

        if (load_rsp)
        begin
            out_valid_next = 1'b1;
            out_data_next  = dq_pkg::make_rsp(status_v, front_next, back_next, count_next);
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_data_reg;

    // The count never exceeds the ring size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= dq_pkg::CNT_BITS'(dq_pkg::DEPTH))
        else $error("queue count beyond ring size");

    // A fetch is only outstanding while the response register is free.
    a_read_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dq_pkg::S_READ) |-> !out_valid_reg)
        else $error("fetch pending while a response is held");

    // A fetch completes in the next cycle and yields a response.
    a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dq_pkg::S_READ) |=> (state_reg == dq_pkg::S_IDLE) && out_valid_reg)
        else $error("fetch did not complete");

    // The store is never written and read in the same cycle.
    a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en))
        else $error("store written and read together");

    // A held response agrees with itself on emptiness.
    a_rsp_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.empty_flag == (out_data_reg.occupancy == '0)))
        else $error("empty flag disagrees with occupancy");

endmodule
